FILE: hw/rtl/setq_pkg.sv
// setq_pkg: sizes, codes and shared types of the sorted expiry timer queue
// no dependencies; used by the interfaces, the cell and the top level

package setq_pkg;

    // storage sizes
    localparam int CAPACITY  = 64;
    localparam int TIME_BITS = 32;
    localparam int ID_BITS   = 16;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    // port field widths
    localparam int REQ_W    = 2;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 7;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_ADJUST = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_NONE_DUE  = 3'd5
    } t_status;

    // one stored timer
    typedef struct packed {
        logic [TIME_BITS-1:0] expiry;
        logic [ID_BITS-1:0]   ident;
    } t_entry;

    // per-cell load select for one cycle
    typedef struct packed {
        logic take_new;
        logic take_left;
        logic take_right;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/setq_req_if.sv
// setq_req_if: request channel of the timer queue, valid/ready plus payload
// depends on setq_pkg for field widths

interface setq_req_if;
    logic                         valid;
    logic                         ready;
    logic [setq_pkg::REQ_W-1:0]   req_type;
    logic [setq_pkg::ID_W-1:0]    timer_id;
    logic [setq_pkg::TIME_W-1:0]  expire_time;
    logic [setq_pkg::TIME_W-1:0]  now_time;

    modport source (output valid, req_type, timer_id, expire_time, now_time, input ready);
    modport sink   (input valid, req_type, timer_id, expire_time, now_time, output ready);
endinterface

FILE: hw/rtl/setq_rsp_if.sv
// setq_rsp_if: result channel of the timer queue, valid/ready plus payload
// depends on setq_pkg for field widths

interface setq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [setq_pkg::STATUS_W-1:0]  status;
    logic [setq_pkg::ID_W-1:0]      expired_id;
    logic                           last;
    logic [setq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, status, expired_id, last, occupancy, input ready);
    modport sink   (input valid, status, expired_id, last, occupancy, output ready);
endinterface

FILE: hw/rtl/setq_cell.sv
// setq_cell: one slot of the sorted chain, holds a timer and compares it to the key
// depends on setq_pkg for the entry and control types

module setq_cell (
    input  logic                            i_clk,
    input  setq_pkg::t_cell_ctl             i_ctl,
    input  logic                            i_occ,
    input  logic [setq_pkg::TIME_BITS-1:0]  i_key_time,
    input  logic [setq_pkg::ID_BITS-1:0]    i_key_id,
    input  setq_pkg::t_entry                i_left,
    input  setq_pkg::t_entry                i_right,
    output setq_pkg::t_entry                o_entry,
    output logic                            o_gt,
    output logic                            o_hit
);

    setq_pkg::t_entry r_entry;
    setq_pkg::t_entry n_entry;

    // empty slots count as later than any key, so inserts land at the end
    assign o_gt    = !i_occ || (r_entry.expiry > i_key_time);
    assign o_hit   = i_occ && (r_entry.ident == i_key_id);
    assign o_entry = r_entry;

    // load from the key, a neighbor, or hold
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.take_new) begin
            n_entry.expiry = i_key_time;
            n_entry.ident  = i_key_id;
        end else if (i_ctl.take_left) begin
            n_entry = i_left;
        end else if (i_ctl.take_right) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: hw/rtl/sorted_expiry_timer_queue_core.sv
// sorted_expiry_timer_queue_core: request sequencer, chain of setq_cell slots, result register
// sequence: a request is taken in idle and run in the exec state, which registers the result;
//   adjust removes the entry in exec, then reinserts it and registers the result in the insert state;
//   a tick pops one due head per cycle in exec while the result is taken, one result per expired timer
// a stalled result holds the sequencer; no request is taken until it returns to idle
// reset: synchronous active low, clears count, sequencer and result valid; slot data is not reset

module sorted_expiry_timer_queue_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    setq_req_if.sink          i_req,
    setq_rsp_if.source        o_rsp
);

    localparam int CAP = setq_pkg::CAPACITY;
    localparam int CW  = setq_pkg::CNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_INSERT = 3'b100
    } t_state;

    t_state r_state, n_state;

    // latched request
    setq_pkg::t_req                 r_req;
    logic [setq_pkg::ID_BITS-1:0]   r_id;
    logic [setq_pkg::TIME_BITS-1:0] r_key;
    logic [setq_pkg::TIME_BITS-1:0] r_exp;

    logic [CW-1:0] r_count, n_count;

    // result register
    logic                      r_out_valid, n_out_valid;
    setq_pkg::t_status         r_status, n_status;
    logic [setq_pkg::ID_W-1:0] r_out_id, n_out_id;
    logic                      r_last, n_last;
    logic [CW-1:0]             r_occ, n_occ;

    // chain wiring
    setq_pkg::t_entry            w_entry [CAP];
    setq_pkg::t_cell_ctl         w_ctl   [CAP];
    logic [CAP-1:0]              w_gt;
    logic [CAP-1:0]              w_hit;
    logic [CAP-1:0]              w_seen;
    logic [setq_pkg::TIME_BITS-1:0] w_key;

    logic in_xfer, can_emit, found, due0, due1;
    logic op_ins, op_rem, op_pop, emit;
    setq_pkg::t_status e_status;
    logic [setq_pkg::ID_W-1:0] e_id;
    logic e_last;

    // request side
    assign i_req.ready = (r_state == S_IDLE);
    assign in_xfer     = i_req.valid && i_req.ready;
    assign can_emit    = !r_out_valid || o_rsp.ready;

    // adjust reinserts with the new expiry, all else compares against the latched key
    assign w_key = (r_state == S_INSERT) ? r_exp : r_key;

    assign found = |w_hit;
    assign due0  = !w_gt[0];
    assign due1  = !w_gt[1];

    // cells of the chain and their load selects
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        // prefix of hits: the matching slot and all after it pull from the right
        assign w_seen[i] = |w_hit[i:0];

        if (i == 0) begin : g_head
            assign w_ctl[i].take_new  = op_ins && w_gt[i];
            assign w_ctl[i].take_left = 1'b0;
        end else begin : g_body
            assign w_ctl[i].take_new  = op_ins && w_gt[i] && !w_gt[i-1];
            assign w_ctl[i].take_left = op_ins && w_gt[i] && w_gt[i-1];
        end
        assign w_ctl[i].take_right = op_pop || (op_rem && w_seen[i]);

        setq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[i]),
            .i_occ      (CW'(i) < r_count),
            .i_key_time (w_key),
            .i_key_id   (r_id),
            .i_left     ((i == 0) ? w_entry[0] : w_entry[(i == 0) ? 0 : i-1]),
            .i_right    (w_entry[(i == CAP-1) ? i : i+1]),
            .o_entry    (w_entry[i]),
            .o_gt       (w_gt[i]),
            .o_hit      (w_hit[i])
        );
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        op_ins   = 1'b0;
        op_rem   = 1'b0;
        op_pop   = 1'b0;
        emit     = 1'b0;
        e_status = setq_pkg::ST_OK;
        e_id     = '0;
        e_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_emit) begin
                    n_state = S_IDLE;
                    case (r_req)
                        setq_pkg::REQ_ADD: begin
                            emit = 1'b1;
                            if (found) begin
                                e_status = setq_pkg::ST_DUPLICATE;
                            end else if (r_count == CW'(CAP)) begin
                                e_status = setq_pkg::ST_FULL;
                            end else begin
                                op_ins  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        setq_pkg::REQ_ADJUST: begin
                            if (found) begin
                                op_rem  = 1'b1;
                                n_count = r_count - 1'b1;
                                n_state = S_INSERT;
                            end else begin
                                emit     = 1'b1;
                                e_status = setq_pkg::ST_NOT_FOUND;
                            end
                        end
                        setq_pkg::REQ_DELETE: begin
                            emit = 1'b1;
                            if (found) begin
                                op_rem  = 1'b1;
                                n_count = r_count - 1'b1;
                            end else begin
                                e_status = setq_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            // tick: pop the head while it is due
                            emit = 1'b1;
                            if (due0) begin
                                op_pop   = 1'b1;
                                n_count  = r_count - 1'b1;
                                e_status = setq_pkg::ST_EXPIRED;
                                e_id     = setq_pkg::ID_W'(w_entry[0].ident);
                                e_last   = !due1;
                                if (due1) begin
                                    n_state = S_EXEC;
                                end
                            end else begin
                                e_status = setq_pkg::ST_NONE_DUE;
                            end
                        end
                    endcase
                end
            end
            S_INSERT: begin
                if (can_emit) begin
                    op_ins  = 1'b1;
                    n_count = r_count + 1'b1;
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result register next values
    always_comb begin
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_out_id    = r_out_id;
        n_last      = r_last;
        n_occ       = r_occ;
        if (emit) begin
            n_out_valid = 1'b1;
            n_status    = e_status;
            n_out_id    = e_id;
            n_last      = e_last;
            n_occ       = n_count;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= setq_pkg::t_req'(i_req.req_type);
            r_id  <= setq_pkg::ID_BITS'(i_req.timer_id);
            r_exp <= setq_pkg::TIME_BITS'(i_req.expire_time);
            r_key <= (setq_pkg::t_req'(i_req.req_type) == setq_pkg::REQ_TICK)
                   ? setq_pkg::TIME_BITS'(i_req.now_time)
                   : setq_pkg::TIME_BITS'(i_req.expire_time);
        end
        r_status <= n_status;
        r_out_id <= n_out_id;
        r_last   <= n_last;
        r_occ    <= n_occ;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.expired_id = r_out_id;
    assign o_rsp.last       = r_last;
    assign o_rsp.occupancy  = setq_pkg::OCC_W'(r_occ);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("timer count above capacity");

    a_reinsert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |-> (r_count < CW'(CAP)))
        else $error("adjust reinsert with no free slot");

    a_none_due_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != setq_pkg::ST_EXPIRED)) |-> r_last)
        else $error("single-result status not marked last");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_pop |-> (r_count != '0))
        else $error("expiry pop from empty queue");
`endif

endmodule

FILE: bench/sorted_expiry_timer_queue_core_test.sv
// sorted_expiry_timer_queue_core_test: self-checking bench for the sorted expiry timer queue
// directed and random requests, each result checked against a behavioral copy of the queue
// depends on setq_pkg, setq_req_if, setq_rsp_if and sorted_expiry_timer_queue_core

module sorted_expiry_timer_queue_core_test;

    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_STALL   = 300;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        setq_pkg::t_req                 req_type;
        logic [setq_pkg::ID_W-1:0]      timer_id;
        logic [setq_pkg::TIME_W-1:0]    expire_time;
        logic [setq_pkg::TIME_W-1:0]    now_time;
    } t_timer_req;

    typedef struct packed {
        setq_pkg::t_status              status;
        logic [setq_pkg::ID_W-1:0]      expired_id;
        logic                           last;
        logic [setq_pkg::OCC_W-1:0]     occupancy;
    } t_timer_rsp;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       req_valid = 1'b0;
    t_timer_req req_item  = '0;
    logic       req_taken = 1'b0;
    logic       rsp_ready = 1'b0;

    // idle rates per phase and the long receiver hold-off
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic stall_armed = 1'b0;
    logic stall_used  = 1'b0;
    int stall_left    = 0;

    // behavioral copy of the sorted store
    logic [setq_pkg::TIME_BITS-1:0] model_expiry [setq_pkg::CAPACITY];
    logic [setq_pkg::ID_BITS-1:0]   model_ident  [setq_pkg::CAPACITY];
    int model_count = 0;

    t_timer_req request_backlog[$];
    t_timer_rsp pending_results[$];
    logic [setq_pkg::TIME_W-1:0] gen_now = 32'd1000;

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int n_requests     = 0;
    int n_results      = 0;
    int n_expired      = 0;
    int n_full         = 0;
    int n_duplicate    = 0;
    int n_not_found    = 0;

    setq_req_if req_ch ();
    setq_rsp_if rsp_ch ();

    assign req_ch.valid       = req_valid;
    assign req_ch.req_type    = req_item.req_type;
    assign req_ch.timer_id    = req_item.timer_id;
    assign req_ch.expire_time = req_item.expire_time;
    assign req_ch.now_time    = req_item.now_time;
    assign rsp_ch.ready       = rsp_ready;

    sorted_expiry_timer_queue_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int find_slot(input logic [setq_pkg::ID_BITS-1:0] id);
        for (int i = 0; i < model_count; i++) begin
            if (model_ident[i] == id) return i;
        end
        return -1;
    endfunction

    // close the gap left by a removed entry
    task automatic remove_slot(input int pos);
        for (int i = pos; i + 1 < model_count; i++) begin
            model_expiry[i] = model_expiry[i+1];
            model_ident[i]  = model_ident[i+1];
        end
        if (model_count > 0) model_count--;
    endtask

    // place after every entry with an equal or earlier expiry
    task automatic insert_slot(input logic [setq_pkg::ID_BITS-1:0] id,
                               input logic [setq_pkg::TIME_BITS-1:0] expiry);
        int pos;
        pos = 0;
        while (pos < model_count && model_expiry[pos] <= expiry) pos++;
        for (int i = model_count; i > pos; i--) begin
            model_expiry[i] = model_expiry[i-1];
            model_ident[i]  = model_ident[i-1];
        end
        model_expiry[pos] = expiry;
        model_ident[pos]  = id;
        model_count++;
    endtask

    task automatic post_result(input setq_pkg::t_status st,
                               input logic [setq_pkg::ID_W-1:0] id, input logic fin);
        t_timer_rsp r;
        r.status     = st;
        r.expired_id = id;
        r.last       = fin;
        r.occupancy  = setq_pkg::OCC_W'(model_count);
        pending_results.push_back(r);
    endtask

    // predicted results of one accepted request
    task automatic apply_timer_request(input t_timer_req rq);
        int pos;
        logic [setq_pkg::ID_BITS-1:0]   id;
        logic [setq_pkg::TIME_BITS-1:0] expiry;
        logic [setq_pkg::TIME_BITS-1:0] now;
        logic [setq_pkg::ID_BITS-1:0]   gone;
        id     = rq.timer_id[setq_pkg::ID_BITS-1:0];
        expiry = rq.expire_time[setq_pkg::TIME_BITS-1:0];
        now    = rq.now_time[setq_pkg::TIME_BITS-1:0];
        case (rq.req_type)
            setq_pkg::REQ_ADD: begin
                if (find_slot(id) >= 0) begin
                    post_result(setq_pkg::ST_DUPLICATE, '0, 1'b1);
                end else if (model_count >= setq_pkg::CAPACITY) begin
                    post_result(setq_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    insert_slot(id, expiry);
                    post_result(setq_pkg::ST_OK, '0, 1'b1);
                end
            end
            setq_pkg::REQ_ADJUST: begin
                pos = find_slot(id);
                if (pos < 0) begin
                    post_result(setq_pkg::ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    remove_slot(pos);
                    insert_slot(id, expiry);
                    post_result(setq_pkg::ST_OK, '0, 1'b1);
                end
            end
            setq_pkg::REQ_DELETE: begin
                pos = find_slot(id);
                if (pos < 0) begin
                    post_result(setq_pkg::ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    remove_slot(pos);
                    post_result(setq_pkg::ST_OK, '0, 1'b1);
                end
            end
            default: begin
                if (!(model_count > 0 && model_expiry[0] <= now)) begin
                    post_result(setq_pkg::ST_NONE_DUE, '0, 1'b1);
                end else begin
                    while (model_count > 0 && model_expiry[0] <= now) begin
                        gone = model_ident[0];
                        remove_slot(0);
                        post_result(setq_pkg::ST_EXPIRED, setq_pkg::ID_W'(gone),
                                    !(model_count > 0 && model_expiry[0] <= now));
                    end
                end
            end
        endcase
    endtask

    task automatic push_req(input setq_pkg::t_req kind, input logic [setq_pkg::ID_W-1:0] id,
                            input logic [setq_pkg::TIME_W-1:0] expiry,
                            input logic [setq_pkg::TIME_W-1:0] now);
        t_timer_req rq;
        rq.req_type    = kind;
        rq.timer_id    = id;
        rq.expire_time = expiry;
        rq.now_time    = now;
        request_backlog.push_back(rq);
    endtask

    // mostly a small id pool so hits and misses both happen
    function automatic logic [setq_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) == 0) return setq_pkg::ID_W'($urandom);
        return setq_pkg::ID_W'($urandom_range(0, 79));
    endfunction

    // random mix of adds, adjusts, deletes and ticks on an advancing clock
    task automatic queue_random_requests(input int count);
        int roll;
        logic [setq_pkg::TIME_W-1:0] expiry;
        for (int k = 0; k < count; k++) begin
            roll   = $urandom_range(0, 99);
            expiry = ($urandom_range(0, 15) == 0) ? setq_pkg::TIME_W'($urandom)
                                                  : gen_now + $urandom_range(0, 60);
            if (roll < 40) begin
                push_req(setq_pkg::REQ_ADD, pick_id(), expiry, $urandom);
            end else if (roll < 55) begin
                push_req(setq_pkg::REQ_ADJUST, pick_id(), expiry, $urandom);
            end else if (roll < 70) begin
                push_req(setq_pkg::REQ_DELETE, pick_id(), expiry, $urandom);
            end else begin
                gen_now += $urandom_range(0, 20);
                push_req(setq_pkg::REQ_TICK, pick_id(), $urandom,
                         ($urandom_range(0, 19) == 0) ? setq_pkg::TIME_W'($urandom) : gen_now);
            end
        end
    endtask

    task automatic wait_all_done();
        while (request_backlog.size() != 0 || pending_results.size() != 0) @(posedge i_clk);
    endtask

    // request driver: hold until transfer, then offer the next item or idle
    always @(negedge i_clk) begin
        if (i_rst_n && (!req_valid || req_taken)) begin
            if (request_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                req_valid <= 1'b1;
                req_item  <= request_backlog[0];
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // result ready: random idling, with one long hold-off
    always @(negedge i_clk) begin
        if (stall_armed && !stall_used) begin
            stall_used <= 1'b1;
            stall_left <= LONG_STALL;
            rsp_ready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end else begin
            rsp_ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // request transfer: predict its results
    always @(posedge i_clk) begin
        req_taken <= req_valid && req_ch.ready;
        if (req_valid && req_ch.ready) begin
            void'(request_backlog.pop_front());
            apply_timer_request(req_item);
            n_requests++;
        end
    end

    // result transfer: compare with the oldest prediction
    always @(posedge i_clk) begin
        t_timer_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                report_error("result with no prediction outstanding");
            end else begin
                want = pending_results.pop_front();
                case (want.status)
                    setq_pkg::ST_EXPIRED:   n_expired++;
                    setq_pkg::ST_FULL:      n_full++;
                    setq_pkg::ST_DUPLICATE: n_duplicate++;
                    setq_pkg::ST_NOT_FOUND: n_not_found++;
                    default: ;
                endcase
                if (rsp_ch.status !== want.status)
                    report_error($sformatf("status %0d, predicted %0d",
                                           rsp_ch.status, want.status));
                if (rsp_ch.expired_id !== want.expired_id)
                    report_error($sformatf("expired_id %h, predicted %h",
                                           rsp_ch.expired_id, want.expired_id));
                if (rsp_ch.last !== want.last)
                    report_error($sformatf("last %b, predicted %b", rsp_ch.last, want.last));
                if (rsp_ch.occupancy !== want.occupancy)
                    report_error($sformatf("occupancy %0d, predicted %0d",
                                           rsp_ch.occupancy, want.occupancy));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("sorted_expiry_timer_queue_core_test: done, errors");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // phase one: sender idles a little, receiver a lot
        send_idle_pct = 16;
        recv_idle_pct = 59;

        // directed: empty tick, field extremes, misses, equal expiries, adjust both ways
        push_req(setq_pkg::REQ_TICK,   16'h0000, 32'h0,        32'h0);
        push_req(setq_pkg::REQ_ADD,    16'h0000, 32'h0,        32'h0);
        push_req(setq_pkg::REQ_ADD,    16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push_req(setq_pkg::REQ_ADD,    16'h0000, 32'd5,        32'h0);
        push_req(setq_pkg::REQ_ADJUST, 16'h1234, 32'd7,        32'h0);
        push_req(setq_pkg::REQ_DELETE, 16'h1234, 32'h0,        32'h0);
        push_req(setq_pkg::REQ_ADD,    16'd10,   32'd100,      32'h0);
        push_req(setq_pkg::REQ_ADD,    16'd11,   32'd100,      32'h0);
        push_req(setq_pkg::REQ_ADD,    16'd12,   32'd100,      32'h0);
        push_req(setq_pkg::REQ_ADJUST, 16'd12,   32'd50,       32'h0);
        push_req(setq_pkg::REQ_ADJUST, 16'd10,   32'd100,      32'h0);
        push_req(setq_pkg::REQ_ADJUST, 16'h0000, 32'd200,      32'h0);
        push_req(setq_pkg::REQ_TICK,   16'h0000, 32'h0,        32'd49);
        push_req(setq_pkg::REQ_TICK,   16'h0000, 32'h0,        32'd100);
        push_req(setq_pkg::REQ_DELETE, 16'h0000, 32'h0,        32'h0);
        push_req(setq_pkg::REQ_DELETE, 16'h0000, 32'h0,        32'h0);
        push_req(setq_pkg::REQ_TICK,   16'h0000, 32'h0,        32'hFFFFFFFE);
        push_req(setq_pkg::REQ_TICK,   16'h0000, 32'h0,        32'hFFFFFFFF);
        push_req(setq_pkg::REQ_TICK,   16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push_req(setq_pkg::REQ_ADJUST, 16'd10,   32'd1,        32'h0);
        queue_random_requests(90);
        wait_all_done();

        // phase two: the other way round
        send_idle_pct = 59;
        recv_idle_pct = 16;
        queue_random_requests(100);
        wait_all_done();

        // phase three: no idling; fill to capacity under a long result hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_req(setq_pkg::REQ_TICK, 16'h0000, 32'h0, 32'hFFFFFFFF);
        for (int i = 0; i < setq_pkg::CAPACITY; i++)
            push_req(setq_pkg::REQ_ADD, setq_pkg::ID_W'(300 + i),
                     gen_now + $urandom_range(0, 40), $urandom);
        push_req(setq_pkg::REQ_ADD,    16'd299, gen_now,         32'h0);
        push_req(setq_pkg::REQ_ADD,    16'd300, gen_now,         32'h0);
        push_req(setq_pkg::REQ_ADJUST, 16'd305, gen_now + 1000,  32'h0);
        push_req(setq_pkg::REQ_DELETE, 16'd310, 32'h0,           32'h0);
        push_req(setq_pkg::REQ_ADD,    16'd299, gen_now + 2,     32'h0);
        push_req(setq_pkg::REQ_TICK,   16'h0000, 32'h0,          32'hFFFFFFFF);
        stall_armed = 1'b1;
        queue_random_requests(40);
        wait_all_done();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d predicted results never arrived",
                                   pending_results.size()));
        $display("covered %0d requests and %0d results: %0d expirations, %0d full,",
                 n_requests, n_results, n_expired, n_full);
        $display("%0d duplicate and %0d unknown-id outcomes, %0d mismatches",
                 n_duplicate, n_not_found, mismatch_count);
        if (mismatch_count == 0) begin
            $display("sorted_expiry_timer_queue_core_test: done, clean");
        end else begin
            $display("sorted_expiry_timer_queue_core_test: done, errors");
        end
        $finish;
    end

endmodule
